### design/tvc_pkg.sv
// ----------------------------------------------------------------------------
// tvc_pkg
// Shared types, register codes, widths and the gain table of the two-voice chorus.
// ----------------------------------------------------------------------------
`default_nettype none

package tvc_pkg;

  localparam int SAMPLE_W = 24;
  localparam int ACC_W    = 42;
  localparam int MPL_W    = 16;
  localparam int LAG_W    = 12;
  localparam int NUM_REGS = 7;

  typedef enum logic [2:0] {
    REG_ENABLE   = 3'd0,
    REG_TIME     = 3'd1,
    REG_FEEDBACK = 3'd2,
    REG_RATE     = 3'd3,
    REG_DRY      = 3'd4,
    REG_WET      = 3'd5,
    REG_DEPTH    = 3'd6
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_CALC_MUL,
    ST_CALC_SWING,
    ST_CALC_NUM,
    ST_CALC_DIV,
    ST_CALC_STEP,
    ST_IDLE,
    ST_TAP_POS,
    ST_TAP_RD0,
    ST_TAP_RD1,
    ST_TAP_DIF,
    ST_TAP_MUL,
    ST_TAP_END,
    ST_AVG,
    ST_FB_MUL,
    ST_STORE,
    ST_WET_MUL,
    ST_DRY_MUL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic load;
  } mul_cmd_t;

  // round(k * 0.05) in Q1.15
  localparam logic [15:0] GAIN_TAB [21] = '{
    16'd0,     16'd1638,  16'd3277,  16'd4915,  16'd6554,  16'd8192,  16'd9830,
    16'd11469, 16'd13107, 16'd14746, 16'd16384, 16'd18022, 16'd19661, 16'd21299,
    16'd22938, 16'd24576, 16'd26214, 16'd27853, 16'd29491, 16'd31130, 16'd32768
  };

  function automatic logic [15:0] gain_q15(logic [4:0] sel, logic [4:0] maxv);
    logic [4:0] k;
    k = (sel > maxv) ? maxv : sel;
    return GAIN_TAB[k];
  endfunction

  // sweep rate in tenths of a hertz
  function automatic logic [6:0] rate_tenths(logic [4:0] sel);
    logic [6:0] k;
    k = (sel > 5'd25) ? 7'd25 : {2'b00, sel};
    return (k < 7'd10) ? k + 7'd1 : k * 7'd5 - 7'd35;
  endfunction

endpackage

`default_nettype wire

### design/tvc_smul.sv
// ----------------------------------------------------------------------------
// tvc_smul
// Bit-serial signed by unsigned multiply-accumulate, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tvc_smul (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire tvc_pkg::mul_cmd_t                   cmd_i,
  input  wire logic signed [tvc_pkg::ACC_W-1:0]    init_i,
  input  wire logic signed [tvc_pkg::ACC_W-1:0]    mcand_i,
  input  wire logic        [tvc_pkg::MPL_W-1:0]    mplier_i,
  output logic signed      [tvc_pkg::ACC_W-1:0]    acc_o,
  output logic                                     busy_o
);

  localparam int CntW = $clog2(tvc_pkg::MPL_W + 1);

  logic [CntW-1:0]                    cnt_q;
  logic signed [tvc_pkg::ACC_W-1:0]   acc_q, mc_q;
  logic [tvc_pkg::MPL_W-1:0]          mp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.start) begin
      cnt_q <= CntW'(tvc_pkg::MPL_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      if (cmd_i.load) begin
        acc_q <= init_i;
      end
      mc_q <= mcand_i;
      mp_q <= mplier_i;
    end else if (cnt_q != '0) begin
      if (mp_q[0]) begin
        acc_q <= acc_q + mc_q;
      end
      mc_q <= mc_q <<< 1;
      mp_q <= mp_q >> 1;
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = (cnt_q != '0);

endmodule

`default_nettype wire

### design/two_voice_chorus_effect.sv
// ----------------------------------------------------------------------------
// two_voice_chorus_effect
// Two swept, interpolated taps on a circular delay store, averaged, fed back
// and mixed with the stored sample; pass-through when disabled.
// ----------------------------------------------------------------------------
// an enabled sample passes through five serial multiplies plus reads and steps
// before output; in pass-through the output is registered, the cycle after input
// one sample at a time: a new sample is taken only once the last one is out
// a write to a known register starts a recompute (40-step serial divider per voice)
// after reset the store is cleared one entry a cycle (BUFFER_DEPTH entries, which
// must be a power of two), then the voices are recomputed before the first sample
`default_nettype none

module two_voice_chorus_effect #(
  parameter int BUFFER_DEPTH = 4096,
  parameter int SAMPLE_RATE  = 48000
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic signed [tvc_pkg::SAMPLE_W-1:0] sample_in_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [tvc_pkg::SAMPLE_W-1:0] sample_out_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [2:0]                     cfg_index_i,
  input  wire logic [7:0]                     cfg_data_i
);

  localparam int AW     = $clog2(BUFFER_DEPTH);
  localparam int PW     = AW + 16;
  localparam int SW     = tvc_pkg::SAMPLE_W;
  localparam int AccW   = tvc_pkg::ACC_W;
  localparam int LagW   = tvc_pkg::LAG_W;
  localparam int NumW   = 40;
  localparam int DivK   = 10 * SAMPLE_RATE;
  localparam int RemW   = $clog2(DivK) + 1;
  localparam int DcntW  = $clog2(NumW + 1);

  localparam logic [LagW-1:0] LAG0 [9] = '{
    LagW'((10 * SAMPLE_RATE) / 1000), LagW'((15 * SAMPLE_RATE) / 1000),
    LagW'((20 * SAMPLE_RATE) / 1000), LagW'((25 * SAMPLE_RATE) / 1000),
    LagW'((30 * SAMPLE_RATE) / 1000), LagW'((35 * SAMPLE_RATE) / 1000),
    LagW'((40 * SAMPLE_RATE) / 1000), LagW'((45 * SAMPLE_RATE) / 1000),
    LagW'((50 * SAMPLE_RATE) / 1000)
  };
  localparam logic [LagW-1:0] LAG1 [9] = '{
    LagW'((10 * SAMPLE_RATE * 3) / 4000), LagW'((15 * SAMPLE_RATE * 3) / 4000),
    LagW'((20 * SAMPLE_RATE * 3) / 4000), LagW'((25 * SAMPLE_RATE * 3) / 4000),
    LagW'((30 * SAMPLE_RATE * 3) / 4000), LagW'((35 * SAMPLE_RATE * 3) / 4000),
    LagW'((40 * SAMPLE_RATE * 3) / 4000), LagW'((45 * SAMPLE_RATE * 3) / 4000),
    LagW'((50 * SAMPLE_RATE * 3) / 4000)
  };

  // shift right by 15 or 16, rounding toward zero
  function automatic logic signed [AccW-1:0] div_q15(logic signed [AccW-1:0] a);
    logic signed [AccW-1:0] q;
    q = a >>> 15;
    if (a[AccW-1] && (a[14:0] != '0)) q = q + AccW'(1);
    return q;
  endfunction

  function automatic logic signed [AccW-1:0] div_q16(logic signed [AccW-1:0] a);
    logic signed [AccW-1:0] q;
    q = a >>> 16;
    if (a[AccW-1] && (a[15:0] != '0)) q = q + AccW'(1);
    return q;
  endfunction

  function automatic logic signed [SW-1:0] sat(logic signed [AccW-1:0] a);
    logic signed [AccW-1:0] hi, lo;
    hi = AccW'((64'sd1 <<< (SW - 1)) - 64'sd1);
    lo = -hi - AccW'(1);
    if (a > hi) return SW'(hi);
    else if (a < lo) return SW'(lo);
    else return a[SW-1:0];
  endfunction

  // configuration
  logic       enable_q;
  logic [3:0] time_q;
  logic [4:0] fb_q, rate_q, dry_q, wet_q;
  logic [7:0] depth_q;

  tvc_pkg::state_e state_q, state_d;
  logic            voice_q, voice_d;
  logic [AW-1:0]   clr_q, wp_q;
  logic [DcntW-1:0] dcnt_q;
  logic            out_valid_q;
  logic signed [SW-1:0] out_q;

  // voice state
  logic [AW-1:0]        rp_q    [2];
  logic signed [31:0]   off_q   [2];
  logic signed [31:0]   step_q  [2];
  logic signed [31:0]   swing_q [2];

  // datapath
  logic [19:0]          prod_q;
  logic [NumW-1:0]      quo_q;
  logic [RemW-1:0]      rem_q;
  logic                 neg_q;
  logic [AW-1:0]        i0_q;
  logic [15:0]          frac_q;
  logic signed [SW-1:0] d0_q, rdata_q, x_q, c_q, stored_q;
  logic signed [SW-1:0] tap_q [2];

  logic signed [SW-1:0] mem [BUFFER_DEPTH];

  logic in_xfer, cfg_xfer, cfg_known, out_free;
  tvc_pkg::mul_cmd_t         mul_cmd;
  logic signed [AccW-1:0]    mul_init, mul_mcand, mul_acc;
  logic [tvc_pkg::MPL_W-1:0] mul_mplier;
  logic                      mul_busy;

  logic [LagW-1:0]       lag_c;
  logic [AW-1:0]         raddr_c;
  logic                  we_c;
  logic [AW-1:0]         waddr_c;
  logic signed [SW-1:0]  wdata_c, stored_c, y_c, c_c;
  logic signed [SW:0]    diff_c, tsum_c;
  logic [PW-1:0]         pos_c;
  logic signed [31:0]    noff_c, nstep_c, lo_c, hi_c;
  logic [8:0]            rmul_c;
  logic signed [40:0]    num_c;
  logic [NumW-1:0]       mag_c;
  logic [RemW-1:0]       rem_c;
  logic                  qbit_c;
  logic [3:0]            tsel_c;

  assign out_free   = !out_valid_q || out_ready_i;
  // a pending register write goes first
  assign in_ready_o = (state_q == tvc_pkg::ST_IDLE) && out_free && !cfg_valid_i;
  assign cfg_ready_o = (state_q == tvc_pkg::ST_IDLE) || (state_q == tvc_pkg::ST_CLEAR);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign cfg_xfer   = cfg_valid_i && cfg_ready_o;
  assign cfg_known  = (cfg_index_i < 3'(tvc_pkg::NUM_REGS));

  // datapath terms
  always_comb begin
    tsel_c  = (time_q > 4'd8) ? 4'd8 : time_q;
    lag_c   = voice_q ? LAG1[tsel_c] : LAG0[tsel_c];
    rmul_c  = voice_q ? 9'(tvc_pkg::rate_tenths(rate_q)) * 9'd3
                      : {tvc_pkg::rate_tenths(rate_q), 2'b00};
    num_c   = 41'(swing_q[voice_q]) * $signed({32'd0, rmul_c});
    mag_c   = num_c[40] ? NumW'(-num_c) : NumW'(num_c);
    rem_c   = {rem_q[RemW-2:0], quo_q[NumW-1]};
    qbit_c  = (rem_c >= RemW'(DivK));
    if (qbit_c) rem_c = rem_c - RemW'(DivK);

    pos_c   = {rp_q[voice_q], 16'd0} + off_q[voice_q][PW-1:0];
    lo_c    = -swing_q[voice_q];
    hi_c    = swing_q[voice_q];
    noff_c  = off_q[voice_q] + step_q[voice_q];
    nstep_c = step_q[voice_q];
    if (noff_c <= lo_c) begin
      nstep_c = -nstep_c;
      noff_c  = lo_c;
    end
    if (noff_c >= hi_c) begin
      nstep_c = -nstep_c;
      noff_c  = hi_c;
    end

    diff_c   = {rdata_q[SW-1], rdata_q} - {d0_q[SW-1], d0_q};
    tsum_c   = {tap_q[0][SW-1], tap_q[0]} + {tap_q[1][SW-1], tap_q[1]};
    c_c      = tsum_c[SW:1] + SW'(tsum_c[SW] & tsum_c[0]);
    stored_c = sat(div_q15(mul_acc));
    y_c      = stored_c;
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    voice_d    = voice_q;
    mul_cmd    = '0;
    mul_init   = '0;
    mul_mcand  = '0;
    mul_mplier = '0;
    raddr_c    = i0_q;
    we_c       = 1'b0;
    waddr_c    = wp_q;
    wdata_c    = stored_c;
    unique case (state_q)
      tvc_pkg::ST_CLEAR: begin
        we_c    = 1'b1;
        waddr_c = clr_q;
        wdata_c = '0;
        if (clr_q == '1) begin
          state_d = tvc_pkg::ST_CALC_MUL;
          voice_d = 1'b0;
        end
      end
      tvc_pkg::ST_CALC_MUL:   state_d = tvc_pkg::ST_CALC_SWING;
      tvc_pkg::ST_CALC_SWING: state_d = tvc_pkg::ST_CALC_NUM;
      tvc_pkg::ST_CALC_NUM:   state_d = tvc_pkg::ST_CALC_DIV;
      tvc_pkg::ST_CALC_DIV: begin
        if (dcnt_q == DcntW'(1)) state_d = tvc_pkg::ST_CALC_STEP;
      end
      tvc_pkg::ST_CALC_STEP: begin
        if (voice_q) begin
          state_d = tvc_pkg::ST_IDLE;
        end else begin
          state_d = tvc_pkg::ST_CALC_MUL;
          voice_d = 1'b1;
        end
      end
      tvc_pkg::ST_IDLE: begin
        voice_d = 1'b0;
        if (cfg_xfer && cfg_known) begin
          state_d = tvc_pkg::ST_CALC_MUL;
        end else if (in_xfer && enable_q) begin
          state_d = tvc_pkg::ST_TAP_POS;
        end
      end
      tvc_pkg::ST_TAP_POS: state_d = tvc_pkg::ST_TAP_RD0;
      tvc_pkg::ST_TAP_RD0: state_d = tvc_pkg::ST_TAP_RD1;
      tvc_pkg::ST_TAP_RD1: begin
        raddr_c = i0_q + AW'(1);
        state_d = tvc_pkg::ST_TAP_DIF;
      end
      tvc_pkg::ST_TAP_DIF: begin
        mul_cmd    = '{start: 1'b1, load: 1'b1};
        mul_init   = AccW'(d0_q) <<< 16;
        mul_mcand  = AccW'(diff_c);
        mul_mplier = frac_q;
        state_d    = tvc_pkg::ST_TAP_MUL;
      end
      tvc_pkg::ST_TAP_MUL: begin
        if (!mul_busy) state_d = tvc_pkg::ST_TAP_END;
      end
      tvc_pkg::ST_TAP_END: begin
        if (voice_q) begin
          state_d = tvc_pkg::ST_AVG;
        end else begin
          state_d = tvc_pkg::ST_TAP_POS;
          voice_d = 1'b1;
        end
      end
      tvc_pkg::ST_AVG: begin
        mul_cmd    = '{start: 1'b1, load: 1'b1};
        mul_init   = AccW'(x_q) <<< 15;
        mul_mcand  = AccW'(c_c);
        mul_mplier = tvc_pkg::gain_q15(fb_q, 5'd19);
        state_d    = tvc_pkg::ST_FB_MUL;
      end
      tvc_pkg::ST_FB_MUL: begin
        if (!mul_busy) state_d = tvc_pkg::ST_STORE;
      end
      tvc_pkg::ST_STORE: begin
        we_c       = 1'b1;
        mul_cmd    = '{start: 1'b1, load: 1'b1};
        mul_mcand  = AccW'(c_q);
        mul_mplier = tvc_pkg::gain_q15(wet_q, 5'd20);
        state_d    = tvc_pkg::ST_WET_MUL;
      end
      tvc_pkg::ST_WET_MUL: begin
        if (!mul_busy) begin
          mul_cmd    = '{start: 1'b1, load: 1'b0};
          mul_mcand  = AccW'(stored_q);
          mul_mplier = tvc_pkg::gain_q15(dry_q, 5'd20);
          state_d    = tvc_pkg::ST_DRY_MUL;
        end
      end
      tvc_pkg::ST_DRY_MUL: begin
        if (!mul_busy) state_d = tvc_pkg::ST_OUT;
      end
      tvc_pkg::ST_OUT: begin
        if (out_free) state_d = tvc_pkg::ST_IDLE;
      end
      default: state_d = tvc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tvc_pkg::ST_CLEAR;
      voice_q     <= 1'b0;
      clr_q       <= '0;
      dcnt_q      <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
      enable_q    <= 1'b0;
      time_q      <= 4'd0;
      fb_q        <= 5'd5;
      rate_q      <= 5'd4;
      dry_q       <= 5'd15;
      wet_q       <= 5'd15;
      depth_q     <= 8'd205;
    end else begin
      state_q <= state_d;
      voice_q <= voice_d;
      if (state_q == tvc_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (state_q == tvc_pkg::ST_CALC_NUM) begin
        dcnt_q <= DcntW'(NumW);
      end else if (dcnt_q != '0) begin
        dcnt_q <= dcnt_q - DcntW'(1);
      end
      if (cfg_xfer) begin
        unique case (cfg_index_i)
          tvc_pkg::REG_ENABLE:   enable_q <= cfg_data_i[0];
          tvc_pkg::REG_TIME:     time_q   <= cfg_data_i[3:0];
          tvc_pkg::REG_FEEDBACK: fb_q     <= cfg_data_i[4:0];
          tvc_pkg::REG_RATE:     rate_q   <= cfg_data_i[4:0];
          tvc_pkg::REG_DRY:      dry_q    <= cfg_data_i[4:0];
          tvc_pkg::REG_WET:      wet_q    <= cfg_data_i[4:0];
          tvc_pkg::REG_DEPTH:    depth_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if ((state_q == tvc_pkg::ST_OUT) && out_free) begin
        wp_q        <= wp_q + AW'(1);
        out_valid_q <= 1'b1;
      end else if (in_xfer && !enable_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) x_q <= sample_in_i;
    if (in_xfer && !enable_q) out_q <= sample_in_i;
    unique case (state_q)
      tvc_pkg::ST_CALC_MUL: prod_q <= 20'(depth_q) * 20'(lag_c);
      tvc_pkg::ST_CALC_SWING: begin
        if (voice_q) begin
          swing_q[1] <= (32'(prod_q) <<< 7) + (32'(prod_q) <<< 6) - 32'sd131072;
          off_q[1]   <= 32'sd131072 - (32'(prod_q) <<< 7) - (32'(prod_q) <<< 6);
        end else begin
          swing_q[0] <= (32'(prod_q) <<< 8) - 32'sd131072;
          off_q[0]   <= 32'sd131072 - (32'(prod_q) <<< 8);
        end
        rp_q[voice_q] <= wp_q - AW'(lag_c);
      end
      tvc_pkg::ST_CALC_NUM: begin
        neg_q <= num_c[40];
        quo_q <= mag_c;
        rem_q <= '0;
      end
      tvc_pkg::ST_CALC_DIV: begin
        rem_q <= rem_c;
        quo_q <= {quo_q[NumW-2:0], qbit_c};
      end
      tvc_pkg::ST_CALC_STEP: begin
        step_q[voice_q] <= neg_q ? -quo_q[31:0] : quo_q[31:0];
      end
      tvc_pkg::ST_TAP_POS: begin
        i0_q            <= pos_c[PW-1:16];
        frac_q          <= pos_c[15:0];
        off_q[voice_q]  <= noff_c;
        step_q[voice_q] <= nstep_c;
      end
      tvc_pkg::ST_TAP_RD1: d0_q <= rdata_q;
      tvc_pkg::ST_TAP_END: tap_q[voice_q] <= sat(div_q16(mul_acc));
      tvc_pkg::ST_AVG:     c_q <= c_c;
      tvc_pkg::ST_STORE:   stored_q <= stored_c;
      tvc_pkg::ST_OUT: begin
        if (out_free) begin
          out_q    <= y_c;
          rp_q[0]  <= rp_q[0] + AW'(1);
          rp_q[1]  <= rp_q[1] + AW'(1);
        end
      end
      default: ;
    endcase
  end

  // delay store
  always_ff @(posedge clk_i) begin
    if (we_c) mem[waddr_c] <= wdata_c;
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_c];
  end

  tvc_smul u_smul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (mul_cmd),
    .init_i   (mul_init),
    .mcand_i  (mul_mcand),
    .mplier_i (mul_mplier),
    .acc_o    (mul_acc),
    .busy_o   (mul_busy)
  );

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  // pass-through transfer shows up on the next cycle unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !enable_q) |=> (out_valid_o && (sample_out_o == $past(sample_in_i))))
    else $error("pass-through sample not forwarded");

  // a known register write starts a recompute and blocks samples
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_xfer && cfg_known && (state_q == tvc_pkg::ST_IDLE)) |=> !in_ready_o)
    else $error("sample accepted during recompute");

  // an enabled sample occupies the datapath
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && enable_q) |=> (!in_ready_o && !cfg_ready_o))
    else $error("new transfer taken while sample in flight");

endmodule

`default_nettype wire
